### hdl/adaptive_proposal_scale_tuner_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the proposal scale tuner
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_PROPOSAL_SCALE_TUNER_MACROS_SVH
`define ADAPTIVE_PROPOSAL_SCALE_TUNER_MACROS_SVH

// antecedent implies consequent in the next cycle, off during reset
`define APST_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apst check failed");

// antecedent implies consequent in the same cycle, off during reset
`define APST_CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apst check failed");

// state right after a reset cycle
`define APST_CHK_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("apst check failed");

`endif

### hdl/apst_pkg.sv
// ---------------------------------------------------------------------------
// apst_pkg
// Types, widths, microcode encoding and program ROM of the scale tuner.
// ---------------------------------------------------------------------------
package apst_pkg;

  localparam int SCALE_W = 32;
  localparam int SUM_W   = 56;
  localparam int TOT_W   = 40;
  localparam int ITER_W  = 24;
  localparam int CNT_W   = 16;
  localparam int DCNT_W  = 6;
  localparam int STEP_W  = 5;

  // floor(n/5) = (n * DIV5_MUL) >> DIV5_SHIFT for any 24-bit n
  localparam logic [ITER_W-1:0] DIV5_MUL   = 24'hCCCCCD;
  localparam int                DIV5_SHIFT = 26;

  localparam logic [ITER_W-1:0]  ADAPT_RST = 24'd1000;
  localparam logic [0:0]         REG_INIT_SCALE  = 1'b0;
  localparam logic [0:0]         REG_ADAPT_LEN   = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FLAGS,
    OP_RDIV,
    OP_RATE,
    OP_WGT,
    OP_MUL_WS,
    OP_ACC,
    OP_MUL_K,
    OP_FAC,
    OP_MUL_SF,
    OP_SCALE,
    OP_EMPTY,
    OP_ENDCLR,
    OP_MDIV,
    OP_MEAN,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_GOTO,
    J_IF,
    J_WAIT
  } jmp_t;

  typedef enum logic [2:0] {
    C_TRUE,
    C_IN,
    C_DIV,
    C_OUT,
    C_SKIP,
    C_NOT_END,
    C_TOT_ZERO
  } cnd_t;

  typedef struct packed {
    op_t   op;
    jmp_t  jmp;
    cnd_t  cnd;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic div_done;
    logic out_free;
    logic skip;
    logic not_end;
    logic tot_zero;
  } status_t;

  localparam step_t S_IDLE   = 5'd0;
  localparam step_t S_FLAGS  = 5'd1;
  localparam step_t S_BRANCH = 5'd2;
  localparam step_t S_RDIV   = 5'd3;
  localparam step_t S_RWAIT  = 5'd4;
  localparam step_t S_WGT    = 5'd5;
  localparam step_t S_MWS    = 5'd6;
  localparam step_t S_ACC    = 5'd7;
  localparam step_t S_MK     = 5'd8;
  localparam step_t S_FAC    = 5'd9;
  localparam step_t S_MSF    = 5'd10;
  localparam step_t S_SCL    = 5'd11;
  localparam step_t S_EMPTY  = 5'd12;
  localparam step_t S_END    = 5'd13;
  localparam step_t S_TOT    = 5'd14;
  localparam step_t S_MDIV   = 5'd15;
  localparam step_t S_MWAIT  = 5'd16;
  localparam step_t S_EMIT   = 5'd17;

  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    case (pc)
      S_IDLE:   w = '{OP_LOAD,   J_WAIT, C_IN,       S_FLAGS};
      S_FLAGS:  w = '{OP_FLAGS,  J_NEXT, C_TRUE,     S_IDLE};
      S_BRANCH: w = '{OP_NONE,   J_IF,   C_SKIP,     S_EMPTY};
      S_RDIV:   w = '{OP_RDIV,   J_NEXT, C_TRUE,     S_IDLE};
      S_RWAIT:  w = '{OP_RATE,   J_WAIT, C_DIV,      S_WGT};
      S_WGT:    w = '{OP_WGT,    J_NEXT, C_TRUE,     S_IDLE};
      S_MWS:    w = '{OP_MUL_WS, J_NEXT, C_TRUE,     S_IDLE};
      S_ACC:    w = '{OP_ACC,    J_NEXT, C_TRUE,     S_IDLE};
      S_MK:     w = '{OP_MUL_K,  J_NEXT, C_TRUE,     S_IDLE};
      S_FAC:    w = '{OP_FAC,    J_NEXT, C_TRUE,     S_IDLE};
      S_MSF:    w = '{OP_MUL_SF, J_NEXT, C_TRUE,     S_IDLE};
      S_SCL:    w = '{OP_SCALE,  J_GOTO, C_TRUE,     S_END};
      S_EMPTY:  w = '{OP_EMPTY,  J_NEXT, C_TRUE,     S_IDLE};
      S_END:    w = '{OP_NONE,   J_IF,   C_NOT_END,  S_EMIT};
      S_TOT:    w = '{OP_ENDCLR, J_IF,   C_TOT_ZERO, S_EMIT};
      S_MDIV:   w = '{OP_MDIV,   J_NEXT, C_TRUE,     S_IDLE};
      S_MWAIT:  w = '{OP_MEAN,   J_WAIT, C_DIV,      S_EMIT};
      S_EMIT:   w = '{OP_EMIT,   J_WAIT, C_OUT,      S_IDLE};
      default:  w = '{OP_NONE,   J_GOTO, C_TRUE,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/apst_div.sv
// ---------------------------------------------------------------------------
// apst_div
// Restoring divider, one quotient bit per cycle, shared by rate and mean.
// ---------------------------------------------------------------------------
module apst_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [apst_pkg::TOT_W-1:0]        rem0,
  input  logic [apst_pkg::SCALE_W-1:0]      feed_in,
  input  logic [apst_pkg::TOT_W-1:0]        dvsr,
  input  logic [apst_pkg::DCNT_W-1:0]       steps,
  output logic                              done,
  output logic [apst_pkg::SCALE_W-1:0]      quot
);

  localparam int RW = apst_pkg::TOT_W;
  localparam int QW = apst_pkg::SCALE_W;

  logic              busy;
  logic [apst_pkg::DCNT_W-1:0] cnt;
  logic [RW-1:0]     rem;
  logic [QW-1:0]     feed;
  logic [RW-1:0]     dvsr_r;
  logic [RW:0]       trial;
  logic [RW+1:0]     diff;
  logic              ge;

  assign trial = {rem, feed[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvsr_r};
  assign ge    = ~diff[RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == apst_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= rem0;
      feed   <= feed_in;
      dvsr_r <= dvsr;
      quot   <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[RW-1:0] : trial[RW-1:0];
      feed <= {feed[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], ge};
    end
  end

endmodule

### hdl/apst_seq.sv
// ---------------------------------------------------------------------------
// apst_seq
// Microcode sequencer: step counter, program ROM and jump logic.
// ---------------------------------------------------------------------------
module apst_seq (
  input  logic               clk,
  input  logic               rst,
  input  apst_pkg::status_t  status,
  output apst_pkg::ctl_t     ctl,
  output logic               in_ready
);

  apst_pkg::step_t  pc;
  apst_pkg::step_t  pc_next;
  apst_pkg::uword_t uw;
  logic             cond;

  assign uw = apst_pkg::ucode(pc);

  always_comb begin
    case (uw.cnd)
      apst_pkg::C_TRUE:     cond = 1'b1;
      apst_pkg::C_IN:       cond = status.in_valid;
      apst_pkg::C_DIV:      cond = status.div_done;
      apst_pkg::C_OUT:      cond = status.out_free;
      apst_pkg::C_SKIP:     cond = status.skip;
      apst_pkg::C_NOT_END:  cond = status.not_end;
      apst_pkg::C_TOT_ZERO: cond = status.tot_zero;
      default:              cond = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    case (uw.jmp)
      apst_pkg::J_NEXT: pc_next = apst_pkg::step_t'(pc + 1'b1);
      apst_pkg::J_GOTO: pc_next = uw.target;
      apst_pkg::J_IF:   pc_next = cond ? uw.target : apst_pkg::step_t'(pc + 1'b1);
      apst_pkg::J_WAIT: pc_next = cond ? uw.target : pc;
      default:          pc_next = apst_pkg::S_IDLE;
    endcase
  end

  // control outputs; a wait step does its work only when its condition holds
  always_comb begin
    ctl.op   = uw.op;
    ctl.fire = (uw.jmp != apst_pkg::J_WAIT) || cond;
    in_ready = (pc == apst_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= apst_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### hdl/apst_dp.sv
// ---------------------------------------------------------------------------
// apst_dp
// Datapath: state registers, shared multiplier, saturating adders,
// divider and output register, driven by the microcode control word.
// ---------------------------------------------------------------------------
module apst_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  apst_pkg::ctl_t                   ctl,
  output apst_pkg::status_t                status,
  input  logic                             in_valid,
  input  logic [apst_pkg::ITER_W-1:0]      iter,
  input  logic [apst_pkg::CNT_W-1:0]       accepts,
  input  logic [apst_pkg::CNT_W-1:0]       tries,
  input  logic [apst_pkg::SCALE_W-1:0]     init_scale,
  input  logic [apst_pkg::ITER_W-1:0]      adapt_length,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [apst_pkg::SCALE_W-1:0]     out_scale,
  output logic                             out_clear,
  output logic                             out_done
);

  localparam int SW  = apst_pkg::SCALE_W;
  localparam int UW  = apst_pkg::SUM_W;
  localparam int TW  = apst_pkg::TOT_W;
  localparam int IW  = apst_pkg::ITER_W;
  localparam int FW  = FRAC_BITS + 1;
  localparam int MBW = (FW > IW) ? FW : IW;
  localparam int PW  = SW + MBW;

  localparam logic [FW-1:0] ONE_Q  = FW'(1) << FRAC_BITS;
  localparam logic [FW-1:0] HALF_Q = FW'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS-1:0] K618 =
    FRAC_BITS'((64'd618 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [FRAC_BITS-1:0] K382 =
    FRAC_BITS'((64'd382 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  logic [IW-1:0]               iter_r;
  logic [apst_pkg::CNT_W-1:0]  acc_r;
  logic [apst_pkg::CNT_W-1:0]  tries_r;
  logic                        in_adapt;
  logic                        in_window;
  logic                        at_end;
  logic                        nonempty;
  logic                        ovf;
  logic                        clear;
  logic                        done;
  logic [FW-1:0]               rate;
  logic [FW-1:0]               wgt;
  logic [FW-1:0]               fac;
  logic [PW-1:0]               prod;
  logic [SW-1:0]               scale;
  logic [UW-1:0]               sum;
  logic [TW-1:0]               total;

  logic                        go;
  logic                        rate_lt;
  logic                        rate_eq;
  logic [SW-1:0]               mul_a;
  logic [MBW-1:0]              mul_b;
  logic [PW-1:0]               mul_p;
  logic [IW-1:0]               lim5;
  logic [SW:0]                 sum_inc;
  logic [FW-1:0]               tot_inc;
  logic [UW:0]                 sum_add;
  logic [TW:0]                 tot_add;
  logic [UW-1:0]               sum_sat;
  logic [TW-1:0]               tot_sat;
  logic [SW:0]                 sp;
  logic [SW-1:0]               scale_sat;
  logic [FW:0]                 two_r;
  logic [FW-1:0]               wgt_n;
  logic [FW-1:0]               fac_n;
  logic                        mean_ovf;

  logic                        div_start;
  logic                        div_mean;
  logic [TW-1:0]               div_rem0;
  logic [SW-1:0]               div_feed;
  logic [TW-1:0]               div_dvsr;
  logic [apst_pkg::DCNT_W-1:0] div_steps;
  logic                        div_done;
  logic [SW-1:0]               div_quot;

  assign go      = ctl.fire;
  assign rate_lt = rate < HALF_Q;
  assign rate_eq = rate == HALF_Q;

  // shared multiplier operands
  always_comb begin
    case (ctl.op)
      apst_pkg::OP_LOAD: begin
        mul_a = SW'(adapt_length);
        mul_b = MBW'(apst_pkg::DIV5_MUL);
      end
      apst_pkg::OP_MUL_WS: begin
        mul_a = scale;
        mul_b = MBW'(wgt);
      end
      apst_pkg::OP_MUL_K: begin
        mul_a = rate_lt ? SW'(K382) : SW'(K618);
        mul_b = rate_lt ? MBW'(rate) : MBW'(rate - HALF_Q);
      end
      apst_pkg::OP_MUL_SF: begin
        mul_a = scale;
        mul_b = MBW'(fac);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);
  assign lim5  = IW'(prod >> apst_pkg::DIV5_SHIFT);

  // accumulators
  always_comb begin
    if (ctl.op == apst_pkg::OP_EMPTY) begin
      sum_inc = {1'b0, init_scale};
      tot_inc = ONE_Q;
    end else begin
      sum_inc = prod[FRAC_BITS+SW:FRAC_BITS];
      tot_inc = wgt;
    end
    sum_add = {1'b0, sum} + (UW+1)'(sum_inc);
    tot_add = {1'b0, total} + (TW+1)'(tot_inc);
    sum_sat = sum_add[UW] ? {UW{1'b1}} : sum_add[UW-1:0];
    tot_sat = tot_add[TW] ? {TW{1'b1}} : tot_add[TW-1:0];
  end

  assign sp        = prod[FRAC_BITS+SW:FRAC_BITS];
  assign scale_sat = sp[SW] ? {SW{1'b1}} : sp[SW-1:0];

  // weight = 1 - 2*|rate - 1/2|
  assign two_r = {rate, 1'b0};
  assign wgt_n = rate_lt ? FW'(two_r) : FW'(((FW + 1)'(1) << FW) - two_r);
  assign fac_n = FW'(prod >> (FRAC_BITS - 1)) + (rate_lt ? FW'(K618) : ONE_Q);

  // mean >= 2^32 exactly when sum >= total * 2^(32-F)
  assign mean_ovf = (sum >> (SW - FRAC_BITS)) >= UW'(total);

  // divider operands
  assign div_mean  = (ctl.op == apst_pkg::OP_MDIV);
  assign div_start = go && ((ctl.op == apst_pkg::OP_RDIV) || div_mean);
  always_comb begin
    if (div_mean) begin
      div_rem0  = TW'(sum >> (SW - FRAC_BITS));
      div_feed  = SW'(sum << FRAC_BITS);
      div_dvsr  = total;
      div_steps = apst_pkg::DCNT_W'(SW);
    end else begin
      div_rem0  = TW'(acc_r >> 1);
      div_feed  = {acc_r[0], {(SW-1){1'b0}}};
      div_dvsr  = TW'(tries_r);
      div_steps = apst_pkg::DCNT_W'(FW);
    end
  end

  apst_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .rem0    (div_rem0),
    .feed_in (div_feed),
    .dvsr    (div_dvsr),
    .steps   (div_steps),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_comb begin
    status.in_valid = in_valid;
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
    status.skip     = !(in_adapt && nonempty);
    status.not_end  = !at_end;
    status.tot_zero = (total == '0);
  end

  // tuner state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SW'(1) << FRAC_BITS;
      sum       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go && ctl.op == apst_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        case (ctl.op)
          apst_pkg::OP_ACC: begin
            if (in_window) begin
              sum   <= sum_sat;
              total <= tot_sat;
            end
          end
          apst_pkg::OP_EMPTY: begin
            if (in_window) begin
              sum   <= sum_sat;
              total <= tot_sat;
            end
          end
          apst_pkg::OP_SCALE: begin
            if (!rate_eq) begin
              scale <= scale_sat;
            end
          end
          apst_pkg::OP_MEAN: begin
            scale <= ovf ? {SW{1'b1}} : div_quot;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk) begin
    if (go) begin
      case (ctl.op)
        apst_pkg::OP_LOAD: begin
          iter_r  <= iter;
          tries_r <= tries;
          acc_r   <= (accepts > tries) ? tries : accepts;
          prod    <= mul_p;
          clear   <= 1'b0;
          done    <= 1'b0;
        end
        apst_pkg::OP_FLAGS: begin
          in_adapt  <= iter_r <= adapt_length;
          in_window <= (iter_r <= adapt_length) && (iter_r >= lim5);
          at_end    <= iter_r == adapt_length;
          nonempty  <= tries_r != '0;
        end
        apst_pkg::OP_RATE:   rate <= div_quot[FW-1:0];
        apst_pkg::OP_WGT:    wgt  <= wgt_n;
        apst_pkg::OP_MUL_WS: prod <= mul_p;
        apst_pkg::OP_MUL_K:  prod <= mul_p;
        apst_pkg::OP_FAC:    fac  <= fac_n;
        apst_pkg::OP_MUL_SF: prod <= mul_p;
        apst_pkg::OP_SCALE:  clear <= 1'b1;
        apst_pkg::OP_ENDCLR: clear <= 1'b1;
        apst_pkg::OP_MDIV:   ovf  <= mean_ovf;
        apst_pkg::OP_MEAN:   done <= 1'b1;
        apst_pkg::OP_EMIT: begin
          out_scale <= scale;
          out_clear <= clear;
          out_done  <= done;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/adaptive_proposal_scale_tuner.sv
// ---------------------------------------------------------------------------
// adaptive_proposal_scale_tuner
// Adaptive Metropolis proposal scaling, microcoded sequencer over one
// shared multiplier and one bit-serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one adaptation batch per transaction (iter, accepts,
//   tries); m_axis returns one result per batch (scale in Q16.16 for the
//   default FRAC_BITS, clear_counts, adapt_done). Registers are to be
//   written over cfg_we/cfg_addr/cfg_wdata only while no batch is in
//   progress; the block itself does not enforce this. The final iteration
//   also divides for the weighted mean, except when the weight total is
//   zero. The one-bit-per-cycle divider runs FRAC_BITS+1 steps for the
//   rate and 32 steps for the mean. One batch is processed at a time;
//   s_axis_tready is high only while the sequencer waits for a batch.
//   Reset loads the scale with 1.0, clears the sums and the output valid
//   flag. A stalled receiver holds the result in the output register;
//   the next batch is still taken and worked on, and only its result
//   waits until the register is free.
// ---------------------------------------------------------------------------
module adaptive_proposal_scale_tuner #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // iter[23:0], accepts[39:24], tries[55:40]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // scale[31:0], clear_counts[32], adapt_done[33]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int SW = apst_pkg::SCALE_W;
  localparam int IW = apst_pkg::ITER_W;
  localparam int CW = apst_pkg::CNT_W;

  logic [SW-1:0]     init_scale;
  logic [IW-1:0]     adapt_length;
  apst_pkg::ctl_t    ctl;
  apst_pkg::status_t status;
  logic [SW-1:0]     out_scale;
  logic              out_clear;
  logic              out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_scale   <= SW'(1) << FRAC_BITS;
      adapt_length <= apst_pkg::ADAPT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        apst_pkg::REG_INIT_SCALE: init_scale   <= cfg_wdata;
        apst_pkg::REG_ADAPT_LEN:  adapt_length <= cfg_wdata[IW-1:0];
        default: begin
        end
      endcase
    end
  end

  apst_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .ctl      (ctl),
    .in_ready (s_axis_tready)
  );

  apst_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .status       (status),
    .in_valid     (s_axis_tvalid),
    .iter         (s_axis_tdata[IW-1:0]),
    .accepts      (s_axis_tdata[IW+CW-1:IW]),
    .tries        (s_axis_tdata[IW+2*CW-1:IW+CW]),
    .init_scale   (init_scale),
    .adapt_length (adapt_length),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_scale    (out_scale),
    .out_clear    (out_clear),
    .out_done     (out_done)
  );

  assign m_axis_tdata = {6'b000000, out_done, out_clear, out_scale};

endmodule

### hdl/apst_chk.sv
// ---------------------------------------------------------------------------
// apst_chk
// Port-level checker for the proposal scale tuner, bound to the top level.
// ---------------------------------------------------------------------------
`include "adaptive_proposal_scale_tuner_macros.svh"

module apst_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  `APST_CHK_RST(a_rst_idle, !m_axis_tvalid && s_axis_tready)

  `APST_CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // one batch at a time: the sequencer leaves its wait step on accept
  `APST_CHK_NEXT(a_one_batch, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // taking the mean always asks for a counter clear
  `APST_CHK_SAME(a_done_clear, m_axis_tvalid && m_axis_tdata[33], m_axis_tdata[32])

endmodule

bind adaptive_proposal_scale_tuner apst_chk u_apst_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
